// ===== rtl/wlmc_pkg.sv =====
package wlmc_pkg;

   localparam int HoldWidth   = 20;
   localparam int PeriodWidth = 8;
   localparam int ModeWidth   = 3;
   localparam int LedWidth    = 3;
   localparam int AudioWidth  = 2;
   localparam int CsrIdxWidth = 2;
   localparam int CsrDatWidth = 20;

   typedef logic [ModeWidth-1:0]   mode_type;
   typedef logic [LedWidth-1:0]    led_type;
   typedef logic [AudioWidth-1:0]  audio_type;
   typedef logic [HoldWidth-1:0]   hold_type;
   typedef logic [PeriodWidth-1:0] period_type;
   typedef logic [CsrIdxWidth-1:0] csr_idx_type;

   localparam mode_type MODE_CLOSED  = 3'd0;
   localparam mode_type MODE_OPENING = 3'd1;
   localparam mode_type MODE_OPEN    = 3'd2;
   localparam mode_type MODE_CLOSING = 3'd3;
   localparam mode_type MODE_ERROR   = 3'd4;

   localparam led_type LED_NONE = 3'd0;
   localparam led_type LED_OFF  = 3'd1;
   localparam led_type LED_ON   = 3'd2;
   localparam led_type LED_B300 = 3'd3;
   localparam led_type LED_B50  = 3'd4;

   localparam audio_type AUDIO_NONE  = 2'd0;
   localparam audio_type AUDIO_ALARM = 2'd1;
   localparam audio_type AUDIO_STOP  = 2'd2;
   localparam audio_type AUDIO_OPEN  = 2'd3;

   localparam csr_idx_type CSR_OPEN_HOLD    = 2'd0;
   localparam csr_idx_type CSR_MOTOR_PERIOD = 2'd1;
   localparam csr_idx_type CSR_AUDIO_PERIOD = 2'd2;

   localparam hold_type   OPEN_HOLD_RESET    = 20'd10000;
   localparam period_type MOTOR_PERIOD_RESET = 8'd1;
   localparam period_type AUDIO_PERIOD_RESET = 8'd27;
   localparam period_type MOTOR_PRESC_RESET  = 8'd3;
   localparam period_type AUDIO_PRESC_RESET  = 8'd31;

endpackage

// ===== rtl/window_lock_motor_controller.sv =====
// Window lock motor controller.
// req_ channel: one transaction per control-loop pass (tick flag and pin samples).
// rsp_ channel: one transaction per request, carrying motor pin levels, busy level,
//   the last LED and audio commands of the pass, the audio step flag and the state.
// csr_ channel: register writes (0 open hold ms, 1 motor period, 2 audio period);
//   always ready, other indexes ignored. Write only while the block is idle.
// Path: a request lands in the input register and its result is loaded into the
//   result register once that register is free, and that register drives rsp_.
// Throughput: one transaction per cycle while rsp_ready keeps results draining; set by
//   the single evaluation stage between the input register and the result register.
// Reset: state goes to error (lock driven closed), busy high, registers to defaults,
//   both pipeline stages empty.
// Stall: while rsp_ready is low the result holds; the input register still takes
//   one more request, then req_ready drops until the result drains.
module window_lock_motor_controller
   import wlmc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_tick,
   input  logic                   req_open_cmd,
   input  logic                   req_key_absent,
   input  logic                   req_unlock_stop,
   input  logic                   req_lock_stop,
   input  logic                   req_sash_shut,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_drive_enable,
   output logic                   rsp_motor_direction,
   output logic                   rsp_step_level,
   output logic                   rsp_busy_level,
   output logic [LedWidth-1:0]    rsp_open_led_cmd,
   output logic [LedWidth-1:0]    rsp_close_led_cmd,
   output logic [LedWidth-1:0]    rsp_pull_led_cmd,
   output logic [AudioWidth-1:0]  rsp_audio_cmd,
   output logic                   rsp_audio_step,
   output logic [ModeWidth-1:0]   rsp_lock_state,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [CsrDatWidth-1:0] csr_data
);

   hold_type   open_hold_ff;
   period_type motor_period_ff;
   period_type audio_period_ff;

   mode_type   mode_ff, mode_in;
   hold_type   hold_ff, hold_in;
   period_type mpre_ff, mpre_in;
   period_type apre_ff, apre_in;
   logic       pend_ff, pend_in;
   logic       step_ff, step_in;
   logic       en_ff, en_in;
   logic       dir_ff, dir_in;
   logic       busy_ff, busy_in;

   logic s1_valid_ff;
   logic tick_ff, open_ff, key_ff, unl_ff, lck_ff, cls_ff;

   logic       out_valid_ff;
   logic       o_en_ff, o_dir_ff, o_step_ff, o_busy_ff, o_astep_ff;
   led_type    o_led_open_ff, o_led_close_ff, o_led_pull_ff;
   audio_type  o_audio_ff;
   mode_type   o_mode_ff;

   led_type    led_open, led_close, led_pull;
   audio_type  audio;
   logic       astep;
   period_type apre_dec, mpre_dec;
   logic       pend_t;

   logic out_free, s1_go, req_go;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign s1_go     = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign req_go    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         open_hold_ff    <= OPEN_HOLD_RESET;
         motor_period_ff <= MOTOR_PERIOD_RESET;
         audio_period_ff <= AUDIO_PERIOD_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_OPEN_HOLD:    open_hold_ff    <= csr_data;
            CSR_MOTOR_PERIOD: motor_period_ff <= csr_data[PeriodWidth-1:0];
            CSR_AUDIO_PERIOD: audio_period_ff <= csr_data[PeriodWidth-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_go) begin
         tick_ff <= req_tick;
         open_ff <= req_open_cmd;
         key_ff  <= req_key_absent;
         unl_ff  <= req_unlock_stop;
         lck_ff  <= req_lock_stop;
         cls_ff  <= req_sash_shut;
      end
   end

   always_comb begin
      apre_dec  = apre_ff - 8'd1;
      mpre_dec  = mpre_ff - 8'd1;
      led_open  = LED_NONE;
      led_close = LED_NONE;
      led_pull  = LED_NONE;
      audio     = AUDIO_NONE;
      astep     = 1'b0;
      apre_in   = apre_ff;
      mpre_in   = mpre_ff;
      pend_t    = pend_ff;
      hold_in   = hold_ff;
      mode_in   = mode_ff;
      step_in   = step_ff;
      en_in     = en_ff;
      dir_in    = dir_ff;
      busy_in   = busy_ff;

      if (tick_ff) begin
         apre_in = apre_dec;
         if (apre_dec == '0) begin
            astep   = 1'b1;
            apre_in = audio_period_ff;
         end
         mpre_in = mpre_dec;
         if (mpre_dec == '0) begin
            pend_t  = 1'b1;
            mpre_in = motor_period_ff;
         end
         if (hold_ff != '0) begin
            hold_in = hold_ff - 20'd1;
         end
      end
      pend_in = pend_t;

      case (mode_ff)
         MODE_CLOSED: begin
            busy_in   = 1'b0;
            en_in     = 1'b0;
            led_open  = LED_OFF;
            led_close = LED_ON;
            led_pull  = LED_OFF;
            audio     = key_ff ? AUDIO_ALARM : AUDIO_STOP;
            if (open_ff) begin
               busy_in   = 1'b1;
               en_in     = 1'b1;
               dir_in    = 1'b0;
               audio     = AUDIO_OPEN;
               mode_in   = MODE_OPENING;
               led_open  = LED_B300;
               led_close = LED_OFF;
            end
         end
         MODE_OPENING: begin
            dir_in = 1'b0;
            if (unl_ff) begin
               mode_in = MODE_OPEN;
               en_in   = 1'b0;
               hold_in = open_hold_ff;
            end else if (pend_t) begin
               step_in = !step_ff;
               pend_in = 1'b0;
            end
         end
         MODE_OPEN: begin
            led_open = LED_ON;
            if (hold_in == '0) begin
               mode_in   = MODE_CLOSING;
               led_open  = LED_OFF;
               led_close = LED_B300;
               en_in     = 1'b1;
               dir_in    = 1'b1;
            end
         end
         MODE_CLOSING: begin
            dir_in = 1'b1;
            if (cls_ff) begin
               led_pull = LED_OFF;
               if (lck_ff) begin
                  mode_in = MODE_CLOSED;
                  audio   = AUDIO_STOP;
               end else if (pend_t) begin
                  step_in = !step_ff;
                  pend_in = 1'b0;
               end
            end else begin
               led_pull = LED_ON;
            end
         end
         default: begin
            led_pull = LED_B50;
            dir_in   = 1'b1;
            en_in    = 1'b1;
            if (cls_ff) begin
               if (lck_ff) begin
                  mode_in = MODE_CLOSED;
               end else if (pend_t) begin
                  step_in = !step_ff;
                  pend_in = 1'b0;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ERROR;
         hold_ff <= '0;
         mpre_ff <= MOTOR_PRESC_RESET;
         apre_ff <= AUDIO_PRESC_RESET;
         pend_ff <= 1'b0;
         step_ff <= 1'b0;
         en_ff   <= 1'b0;
         dir_ff  <= 1'b0;
         busy_ff <= 1'b1;
      end else if (s1_go) begin
         mode_ff <= mode_in;
         hold_ff <= hold_in;
         mpre_ff <= mpre_in;
         apre_ff <= apre_in;
         pend_ff <= pend_in;
         step_ff <= step_in;
         en_ff   <= en_in;
         dir_ff  <= dir_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         o_en_ff        <= en_in;
         o_dir_ff       <= dir_in;
         o_step_ff      <= step_in;
         o_busy_ff      <= busy_in;
         o_led_open_ff  <= led_open;
         o_led_close_ff <= led_close;
         o_led_pull_ff  <= led_pull;
         o_audio_ff     <= audio;
         o_astep_ff     <= astep;
         o_mode_ff      <= mode_in;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_drive_enable    = o_en_ff;
   assign rsp_motor_direction = o_dir_ff;
   assign rsp_step_level      = o_step_ff;
   assign rsp_busy_level      = o_busy_ff;
   assign rsp_open_led_cmd    = o_led_open_ff;
   assign rsp_close_led_cmd   = o_led_close_ff;
   assign rsp_pull_led_cmd    = o_led_pull_ff;
   assign rsp_audio_cmd       = o_audio_ff;
   assign rsp_audio_step      = o_astep_ff;
   assign rsp_lock_state      = o_mode_ff;

endmodule

// ===== rtl/wlmc_checker.sv =====
module wlmc_checker
   import wlmc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  rsp_drive_enable,
   input logic                  rsp_motor_direction,
   input logic [AudioWidth-1:0] rsp_audio_cmd,
   input logic [ModeWidth-1:0]  rsp_lock_state
);

   // a stalled result stays valid with its lock state unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_lock_state))
      else $error("stalled result changed");

   a_opening_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_lock_state == MODE_OPENING |-> rsp_drive_enable && !rsp_motor_direction)
      else $error("opening without open drive");

   a_closing_dir: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_lock_state == MODE_CLOSING |-> rsp_motor_direction)
      else $error("closing without close direction");

   a_open_song: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_audio_cmd == AUDIO_OPEN |-> rsp_lock_state == MODE_OPENING)
      else $error("open song outside opening");

endmodule

bind window_lock_motor_controller wlmc_checker u_wlmc_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_drive_enable    (rsp_drive_enable),
   .rsp_motor_direction (rsp_motor_direction),
   .rsp_audio_cmd       (rsp_audio_cmd),
   .rsp_lock_state      (rsp_lock_state)
);

// ===== verif/tb_window_lock_motor_controller.sv =====
`timescale 1ns / 1ps

module tb_window_lock_motor_controller;
   import wlmc_pkg::*;

   typedef struct packed {
      logic tick;
      logic open_cmd;
      logic key_absent;
      logic unlock_stop;
      logic lock_stop;
      logic sash_shut;
   } lock_inputs_type;

   typedef struct packed {
      logic      drive_enable;
      logic      motor_direction;
      logic      step_level;
      logic      busy_level;
      led_type   open_led;
      led_type   close_led;
      led_type   pull_led;
      audio_type audio;
      logic      audio_step;
      mode_type  lock_state;
   } lock_outputs_type;

   typedef struct packed {
      logic                   is_write;
      csr_idx_type            reg_index;
      logic [CsrDatWidth-1:0] reg_data;
      lock_inputs_type        pins;
      logic                   typed;
      lock_outputs_type       want;
   } directed_row_type;

   localparam csr_idx_type CSR_UNUSED   = 2'd3;
   localparam int          SETTLE_CYCLES = 10;
   localparam int          STALL_LIMIT   = 1000;
   localparam int          BACKOFF_CYCLES = 100;
   localparam int          PHASES        = 6;
   localparam int          DIRECTED_ROWS = 22;

   // pins: tick, open_cmd, key_absent, unlock_stop, lock_stop, sash_shut
   localparam directed_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{1'b0, CSR_OPEN_HOLD, 20'd0, 6'b000000, 1'b1,
        '{1'b1, 1'b1, 1'b0, 1'b1, LED_NONE, LED_NONE, LED_B50, AUDIO_NONE, 1'b0, MODE_ERROR}},
      '{1'b0, CSR_OPEN_HOLD, 20'd0, 6'b100001, 1'b0, '0},
      '{1'b0, CSR_OPEN_HOLD, 20'd0, 6'b100001, 1'b0, '0},
      '{1'b0, CSR_OPEN_HOLD, 20'd0, 6'b100001, 1'b0, '0},
      '{1'b0, CSR_OPEN_HOLD, 20'd0, 6'b111111, 1'b0, '0},
      '{1'b0, CSR_OPEN_HOLD, 20'd0, 6'b001000, 1'b1,
        '{1'b0, 1'b1, 1'b1, 1'b0, LED_OFF, LED_ON, LED_OFF, AUDIO_ALARM, 1'b0, MODE_CLOSED}},
      '{1'b1, CSR_OPEN_HOLD, 20'd2, 6'b000000, 1'b0, '0},
      '{1'b0, CSR_OPEN_HOLD, 20'd0, 6'b000000, 1'b0, '0},
      '{1'b0, CSR_OPEN_HOLD, 20'd0, 6'b011000, 1'b0, '0},
      '{1'b0, CSR_OPEN_HOLD, 20'd0, 6'b000000, 1'b0, '0},
      '{1'b0, CSR_OPEN_HOLD, 20'd0, 6'b100000, 1'b0, '0},
      '{1'b0, CSR_OPEN_HOLD, 20'd0, 6'b100100, 1'b0, '0},
      '{1'b0, CSR_OPEN_HOLD, 20'd0, 6'b100000, 1'b0, '0},
      '{1'b0, CSR_OPEN_HOLD, 20'd0, 6'b100000, 1'b0, '0},
      '{1'b0, CSR_OPEN_HOLD, 20'd0, 6'b000000, 1'b0, '0},
      '{1'b0, CSR_OPEN_HOLD, 20'd0, 6'b000001, 1'b0, '0},
      '{1'b0, CSR_OPEN_HOLD, 20'd0, 6'b000011, 1'b0, '0},
      '{1'b1, CSR_OPEN_HOLD, 20'd0, 6'b000000, 1'b0, '0},
      '{1'b0, CSR_OPEN_HOLD, 20'd0, 6'b010000, 1'b0, '0},
      '{1'b0, CSR_OPEN_HOLD, 20'd0, 6'b000100, 1'b0, '0},
      '{1'b0, CSR_OPEN_HOLD, 20'd0, 6'b000000, 1'b0, '0},
      '{1'b0, CSR_OPEN_HOLD, 20'd0, 6'b000011, 1'b0, '0}
   };

   localparam hold_type   PHASE_HOLD  [PHASES] = '{20'd7, 20'd30, 20'd0, 20'd100, 20'd12,
                                                   20'hFFFFF};
   localparam period_type PHASE_MOTOR [PHASES] = '{8'd1, 8'd2, 8'd0, 8'd255, 8'd5, 8'd1};
   localparam period_type PHASE_AUDIO [PHASES] = '{8'd1, 8'd255, 8'd0, 8'd3, 8'd27, 8'd1};
   localparam int PHASE_ITEMS     [PHASES] = '{300, 300, 300, 300, 300, 150};
   localparam int PHASE_TICK_PCT  [PHASES] = '{70, 60, 95, 90, 75, 50};
   localparam int PHASE_SEND_IDLE [PHASES] = '{17, 17, 58, 58, 0, 0};
   localparam int PHASE_RECV_IDLE [PHASES] = '{58, 58, 17, 17, 0, 0};

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic                   req_tick;
   logic                   req_open_cmd;
   logic                   req_key_absent;
   logic                   req_unlock_stop;
   logic                   req_lock_stop;
   logic                   req_sash_shut;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic                   rsp_drive_enable;
   logic                   rsp_motor_direction;
   logic                   rsp_step_level;
   logic                   rsp_busy_level;
   logic [LedWidth-1:0]    rsp_open_led_cmd;
   logic [LedWidth-1:0]    rsp_close_led_cmd;
   logic [LedWidth-1:0]    rsp_pull_led_cmd;
   logic [AudioWidth-1:0]  rsp_audio_cmd;
   logic                   rsp_audio_step;
   logic [ModeWidth-1:0]   rsp_lock_state;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CsrIdxWidth-1:0] csr_index;
   logic [CsrDatWidth-1:0] csr_data;

   hold_type   cfg_open_hold;
   period_type cfg_motor_period;
   period_type cfg_audio_period;
   mode_type   lock_mode;
   hold_type   hold_left;
   period_type motor_div;
   period_type audio_div;
   logic       step_due;
   logic       step_pin;
   logic       enable_pin;
   logic       dir_pin;
   logic       busy_pin;

   lock_outputs_type predicted_outputs [$];
   int failures = 0;
   int quiet_cycles = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int rsp_backoffs = 0;

   window_lock_motor_controller i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_tick            (req_tick),
      .req_open_cmd        (req_open_cmd),
      .req_key_absent      (req_key_absent),
      .req_unlock_stop     (req_unlock_stop),
      .req_lock_stop       (req_lock_stop),
      .req_sash_shut       (req_sash_shut),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_drive_enable    (rsp_drive_enable),
      .rsp_motor_direction (rsp_motor_direction),
      .rsp_step_level      (rsp_step_level),
      .rsp_busy_level      (rsp_busy_level),
      .rsp_open_led_cmd    (rsp_open_led_cmd),
      .rsp_close_led_cmd   (rsp_close_led_cmd),
      .rsp_pull_led_cmd    (rsp_pull_led_cmd),
      .rsp_audio_cmd       (rsp_audio_cmd),
      .rsp_audio_step      (rsp_audio_step),
      .rsp_lock_state      (rsp_lock_state),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void reset_lock_model();
      cfg_open_hold    = OPEN_HOLD_RESET;
      cfg_motor_period = MOTOR_PERIOD_RESET;
      cfg_audio_period = AUDIO_PERIOD_RESET;
      lock_mode        = MODE_ERROR;
      hold_left        = '0;
      motor_div        = MOTOR_PRESC_RESET;
      audio_div        = AUDIO_PRESC_RESET;
      step_due         = 1'b0;
      step_pin         = 1'b0;
      enable_pin       = 1'b0;
      dir_pin          = 1'b0;
      busy_pin         = 1'b1;
   endfunction

   function automatic lock_outputs_type run_control_pass(input lock_inputs_type p);
      lock_outputs_type r;
      logic             take_step;
      r = '0;
      r.open_led  = LED_NONE;
      r.close_led = LED_NONE;
      r.pull_led  = LED_NONE;
      r.audio     = AUDIO_NONE;
      take_step   = 1'b0;
      if (p.tick) begin
         audio_div = audio_div - 8'd1;
         if (audio_div == '0) begin
            r.audio_step = 1'b1;
            audio_div    = cfg_audio_period;
         end
         motor_div = motor_div - 8'd1;
         if (motor_div == '0) begin
            step_due  = 1'b1;
            motor_div = cfg_motor_period;
         end
         if (hold_left != '0) hold_left = hold_left - 20'd1;
      end
      case (lock_mode)
         MODE_CLOSED: begin
            busy_pin    = 1'b0;
            enable_pin  = 1'b0;
            r.open_led  = LED_OFF;
            r.close_led = LED_ON;
            r.pull_led  = LED_OFF;
            r.audio     = p.key_absent ? AUDIO_ALARM : AUDIO_STOP;
            if (p.open_cmd) begin
               busy_pin    = 1'b1;
               enable_pin  = 1'b1;
               dir_pin     = 1'b0;
               r.audio     = AUDIO_OPEN;
               lock_mode   = MODE_OPENING;
               r.open_led  = LED_B300;
               r.close_led = LED_OFF;
            end
         end
         MODE_OPENING: begin
            dir_pin = 1'b0;
            if (p.unlock_stop) begin
               lock_mode  = MODE_OPEN;
               enable_pin = 1'b0;
               hold_left  = cfg_open_hold;
            end else begin
               take_step = 1'b1;
            end
         end
         MODE_OPEN: begin
            r.open_led = LED_ON;
            if (hold_left == '0) begin
               lock_mode   = MODE_CLOSING;
               r.open_led  = LED_OFF;
               r.close_led = LED_B300;
               enable_pin  = 1'b1;
               dir_pin     = 1'b1;
            end
         end
         MODE_CLOSING: begin
            dir_pin = 1'b1;
            if (p.sash_shut) begin
               r.pull_led = LED_OFF;
               if (p.lock_stop) begin
                  lock_mode = MODE_CLOSED;
                  r.audio   = AUDIO_STOP;
               end else begin
                  take_step = 1'b1;
               end
            end else begin
               r.pull_led = LED_ON;
            end
         end
         default: begin
            r.pull_led = LED_B50;
            dir_pin    = 1'b1;
            enable_pin = 1'b1;
            if (p.sash_shut) begin
               if (p.lock_stop) lock_mode = MODE_CLOSED;
               else take_step = 1'b1;
            end
         end
      endcase
      if (take_step && step_due) begin
         step_pin = ~step_pin;
         step_due = 1'b0;
      end
      r.drive_enable    = enable_pin;
      r.motor_direction = dir_pin;
      r.step_level      = step_pin;
      r.busy_level      = busy_pin;
      r.lock_state      = lock_mode;
      return r;
   endfunction

   task automatic offer_pass(input lock_inputs_type pins, input logic typed,
                             input lock_outputs_type want);
      lock_outputs_type model_out;
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid       <= 1'b1;
      req_tick        <= pins.tick;
      req_open_cmd    <= pins.open_cmd;
      req_key_absent  <= pins.key_absent;
      req_unlock_stop <= pins.unlock_stop;
      req_lock_stop   <= pins.lock_stop;
      req_sash_shut   <= pins.sash_shut;
      do @(posedge clock); while (!req_ready);
      model_out = run_control_pass(pins);
      predicted_outputs.push_back(typed ? want : model_out);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (predicted_outputs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input logic [CsrDatWidth-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_OPEN_HOLD:    cfg_open_hold    = data[HoldWidth-1:0];
         CSR_MOTOR_PERIOD: cfg_motor_period = data[PeriodWidth-1:0];
         CSR_AUDIO_PERIOD: cfg_audio_period = data[PeriodWidth-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin : result_check
      lock_outputs_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_outputs.size() == 0) begin
            $error("result transaction with no pass outstanding");
            failures++;
         end else begin
            want = predicted_outputs.pop_front();
            check_field("drive_enable", 32'(want.drive_enable), 32'(rsp_drive_enable));
            check_field("motor_direction", 32'(want.motor_direction),
                        32'(rsp_motor_direction));
            check_field("step_level", 32'(want.step_level), 32'(rsp_step_level));
            check_field("busy_level", 32'(want.busy_level), 32'(rsp_busy_level));
            check_field("open_led_cmd", 32'(want.open_led), 32'(rsp_open_led_cmd));
            check_field("close_led_cmd", 32'(want.close_led), 32'(rsp_close_led_cmd));
            check_field("pull_led_cmd", 32'(want.pull_led), 32'(rsp_pull_led_cmd));
            check_field("audio_cmd", 32'(want.audio), 32'(rsp_audio_cmd));
            check_field("audio_step", 32'(want.audio_step), 32'(rsp_audio_step));
            check_field("lock_state", 32'(want.lock_state), 32'(rsp_lock_state));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin : result_drain
      int backoff_left;
      int backoffs_seen;
      backoff_left  = 0;
      backoffs_seen = 0;
      rsp_ready     = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_backoffs != backoffs_seen) begin
            backoffs_seen = rsp_backoffs;
            backoff_left  = BACKOFF_CYCLES;
         end
         if (backoff_left > 0) begin
            backoff_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin : stimulus
      lock_inputs_type        pins;
      logic [CsrDatWidth-1:0] wdata;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_tick        = 1'b0;
      req_open_cmd    = 1'b0;
      req_key_absent  = 1'b0;
      req_unlock_stop = 1'b0;
      req_lock_stop   = 1'b0;
      req_sash_shut   = 1'b0;
      csr_valid       = 1'b0;
      csr_index       = CSR_OPEN_HOLD;
      csr_data        = '0;
      send_idle_pct   = PHASE_SEND_IDLE[0];
      recv_idle_pct   = PHASE_RECV_IDLE[0];
      reset_lock_model();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (DIRECTED[i].is_write) begin
            wait_drained();
            write_reg(DIRECTED[i].reg_index, DIRECTED[i].reg_data);
         end else begin
            offer_pass(DIRECTED[i].pins, DIRECTED[i].typed, DIRECTED[i].want);
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         wait_drained();
         send_idle_pct = PHASE_SEND_IDLE[ph];
         recv_idle_pct = PHASE_RECV_IDLE[ph];
         write_reg(CSR_OPEN_HOLD, CsrDatWidth'(PHASE_HOLD[ph]));
         wdata = CsrDatWidth'($urandom);
         wdata[PeriodWidth-1:0] = PHASE_MOTOR[ph];
         write_reg(CSR_MOTOR_PERIOD, wdata);
         wdata = CsrDatWidth'($urandom);
         wdata[PeriodWidth-1:0] = PHASE_AUDIO[ph];
         write_reg(CSR_AUDIO_PERIOD, wdata);
         write_reg(CSR_UNUSED, CsrDatWidth'($urandom));
         for (int n = 0; n < PHASE_ITEMS[ph]; n++) begin
            pins.tick        = ($urandom_range(99) < PHASE_TICK_PCT[ph]);
            pins.open_cmd    = ($urandom_range(99) < 25);
            pins.key_absent  = ($urandom_range(99) < 50);
            pins.unlock_stop = ($urandom_range(99) < 35);
            pins.lock_stop   = ($urandom_range(99) < 50);
            pins.sash_shut   = ($urandom_range(99) < 60);
            if (ph == 1 && n == 100) rsp_backoffs++;
            if (ph == 3 && n == 150) wait_drained();
            offer_pass(pins, 1'b0, '0);
         end
      end

      wait_drained();
      if (failures == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
